FILE: hdl/tpmq_pkg.sv
// Shared constants and types for the tree path-minimum query block.
package tpmq_pkg;

   localparam int MaxNodes = 1024;
   localparam int Levels   = 10;
   localparam int NodeW    = $clog2(MaxNodes);
   localparam int LevelW   = $clog2(Levels);
   localparam int AncW     = NodeW + 1;
   localparam int WeightW  = 31;
   localparam int DepthW   = 10;
   localparam int CountW   = 11;
   localparam int AddrW    = $clog2(Levels * MaxNodes);

   localparam logic [WeightW-1:0] WeightMax = {WeightW{1'b1}};
   localparam logic [AncW-1:0]    NoNode    = AncW'(MaxNodes);

   // Request kinds
   localparam logic [1:0] KindLoad   = 2'd0;
   localparam logic [1:0] KindBuild  = 2'd1;
   localparam logic [1:0] KindQuery  = 2'd2;
   localparam logic [1:0] KindUnused = 2'd3;

   // One lifting-table entry
   typedef struct packed {
      logic [AncW-1:0]    anc;
      logic [WeightW-1:0] wt;
   } entry_type;

   // Flat table address for a level and a node
   function automatic logic [AddrW-1:0] slot_addr(input logic [LevelW-1:0] lv,
                                                  input logic [NodeW-1:0] n);
      slot_addr = AddrW'(lv) * AddrW'(MaxNodes) + AddrW'(n);
   endfunction

endpackage

FILE: hdl/tpmq_ram.sv
// Simple dual-port synchronous RAM with registered read.
module tpmq_ram #(
   parameter int Depth = 1024,
   parameter int Width = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/tree_path_min_query.sv
// Top level: binary-lifting tree path-minimum query engine.
//
//  channel | ports                           | direction
//  req     | req_valid/req_ready + fields    | in
//  rsp     | rsp_valid/rsp_ready + weight    | out
//  csr     | csr_valid/csr_ready + node_count| in
//
// Load: written on acceptance; loads can follow back to back.
// Build: per node per level, states S_BRD0, S_BWAIT0, S_BRD1 and S_BWR (entry read,
// then its ancestor's read, then the write) over levels 1..9, after the accept.
// Query: per lifting level, S_Q1RD and S_Q1W in the depth pass, then S_Q2RDU,
// S_Q2RDV and S_Q2W in the common-ancestor pass. req_ready is low until it ends.
// Reset is synchronous; tables are undefined until loaded and built.
// A finished result waits in rsp registers; the next request is taken meanwhile,
// but a query only completes once that register is free. csr waits for idle.
module tree_path_min_query (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_node,
   input  logic [9:0]  req_other_node,
   input  logic [9:0]  req_parent_node,
   input  logic        req_has_parent,
   input  logic [30:0] req_edge_weight,
   input  logic [9:0]  req_node_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_path_min_weight,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_node_count
);
   localparam int NodeW = tpmq_pkg::NodeW;
   localparam int LevelW = tpmq_pkg::LevelW;
   localparam int AncW = tpmq_pkg::AncW;
   localparam int WeightW = tpmq_pkg::WeightW;
   localparam int DepthW = tpmq_pkg::DepthW;
   localparam int AddrW = tpmq_pkg::AddrW;
   localparam int EntW = AncW + WeightW;

   typedef enum logic [4:0] {
      S_IDLE, S_BRD0, S_BWAIT0, S_BRD1, S_BWR,
      S_QD, S_QDW, S_Q1RD, S_Q1W, S_QCHK, S_Q2RDU, S_Q2RDV, S_Q2W, S_QFIN,
      S_QFW, S_QLAST, S_DONE
   } state_type;

   state_type state_ff;
   logic [NodeW:0] count_ff;
   logic [LevelW-1:0] lv_ff;
   logic [NodeW:0] n_ff;
   logic [NodeW-1:0] u_ff, v_ff;
   logic [DepthW-1:0] du_ff, dv_ff;
   logic [WeightW-1:0] ans_ff;
   tpmq_pkg::entry_type ea_ff;
   logic [LevelW-1:0] top_ff;
   logic nolift_ff;
   logic rsp_valid_ff;
   logic [WeightW-1:0] rsp_wt_ff;

   // Table RAM ports
   logic t_we;
   logic [AddrW-1:0] t_wa, t_ra;
   tpmq_pkg::entry_type t_wd, t_rd;
   logic [EntW-1:0] t_rd_raw;
   logic d_we;
   logic [NodeW-1:0] d_wa, d_ra;
   logic [DepthW-1:0] d_wd, d_rd;

   tpmq_ram #(.Depth(tpmq_pkg::Levels * tpmq_pkg::MaxNodes), .Width(EntW)) u_tab (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra),
      .rd_data(t_rd_raw));
   assign t_rd = t_rd_raw;

   tpmq_ram #(.Depth(tpmq_pkg::MaxNodes), .Width(DepthW)) u_dep (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd), .rd_addr(d_ra),
      .rd_data(d_rd));

   logic acc, rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign acc = req_valid && req_ready;
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_path_min_weight = rsp_wt_ff;

   // floor(log2(d)) capped; zero for d <= 1
   function automatic logic [LevelW-1:0] top_of(input logic [DepthW-1:0] d);
      logic [LevelW-1:0] t;
      t = '0;
      for (int i = 1; i < DepthW; i++) begin
         if (d[i]) t = LevelW'(i);
      end
      if (int'(t) > tpmq_pkg::Levels - 1) t = LevelW'(tpmq_pkg::Levels - 1);
      top_of = t;
   endfunction

   function automatic logic [WeightW-1:0] mn(input logic [WeightW-1:0] a,
                                            input logic [WeightW-1:0] b);
      mn = (a < b) ? a : b;
   endfunction

   // Depth gap of the current pair; top bit set when u sits above v
   logic [DepthW:0] diff;
   assign diff = {1'b0, du_ff} - {1'b0, dv_ff};

   // First pass: take this jump of u
   logic q1_lift;
   assign q1_lift = !diff[DepthW] && (diff >= ((DepthW+1)'(1) << lv_ff))
                    && (t_rd.anc < tpmq_pkg::NoNode);

   // Memory addressing and writes
   always_comb begin
      t_we = 1'b0;
      t_wa = '0;
      t_wd = '0;
      t_ra = '0;
      d_we = 1'b0;
      d_wa = req_node;
      d_wd = req_node_level;
      d_ra = req_node;
      if (acc && req_kind == tpmq_pkg::KindLoad) begin
         t_we = 1'b1;
         t_wa = tpmq_pkg::slot_addr('0, req_node);
         t_wd.anc = req_has_parent ? AncW'(req_parent_node) : tpmq_pkg::NoNode;
         t_wd.wt = req_has_parent ? req_edge_weight : tpmq_pkg::WeightMax;
         d_we = 1'b1;
      end
      case (state_ff)
         S_BRD0: t_ra = tpmq_pkg::slot_addr(lv_ff - 1'b1, n_ff[NodeW-1:0]);
         S_BRD1: t_ra = tpmq_pkg::slot_addr(lv_ff - 1'b1, ea_ff.anc[NodeW-1:0]);
         S_BWR: begin
            t_we = 1'b1;
            t_wa = tpmq_pkg::slot_addr(lv_ff, n_ff[NodeW-1:0]);
            if (ea_ff.anc >= tpmq_pkg::NoNode) begin
               t_wd = ea_ff;
            end else begin
               t_wd.anc = t_rd.anc;
               t_wd.wt = mn(ea_ff.wt, t_rd.wt);
            end
         end
         S_QD: d_ra = v_ff;
         // depth of the deeper node, then of each node u lands on
         S_QDW: d_ra = (du_ff < d_rd) ? v_ff : u_ff;
         S_Q1RD: t_ra = tpmq_pkg::slot_addr(lv_ff, u_ff);
         S_Q1W: d_ra = q1_lift ? t_rd.anc[NodeW-1:0] : u_ff;
         S_Q2RDU: t_ra = tpmq_pkg::slot_addr(lv_ff, u_ff);
         S_Q2RDV: t_ra = tpmq_pkg::slot_addr(lv_ff, v_ff);
         S_QFIN: t_ra = tpmq_pkg::slot_addr('0, u_ff);
         S_QFW: t_ra = tpmq_pkg::slot_addr('0, v_ff);
         default: ;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= 11'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_ff <= (csr_node_count > 11'(tpmq_pkg::MaxNodes))
                        ? 11'(tpmq_pkg::MaxNodes) : csr_node_count;
         end
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (acc) begin
               u_ff <= req_node;
               v_ff <= req_other_node;
               ans_ff <= tpmq_pkg::WeightMax;
               lv_ff <= LevelW'(1);
               n_ff <= '0;
               if (req_kind == tpmq_pkg::KindBuild) begin
                  if (tpmq_pkg::Levels > 1 && count_ff != '0) state_ff <= S_BRD0;
               end else if (req_kind == tpmq_pkg::KindQuery) begin
                  state_ff <= S_QD;
               end
            end
            S_BRD0: state_ff <= S_BWAIT0;
            S_BWAIT0: begin
               ea_ff <= t_rd;
               state_ff <= S_BRD1;
            end
            S_BRD1: state_ff <= S_BWR;
            S_BWR: begin
               if (n_ff + 1'b1 >= count_ff) begin
                  n_ff <= '0;
                  if (int'(lv_ff) == tpmq_pkg::Levels - 1) state_ff <= S_IDLE;
                  else begin
                     lv_ff <= lv_ff + 1'b1;
                     state_ff <= S_BRD0;
                  end
               end else begin
                  n_ff <= n_ff + 1'b1;
                  state_ff <= S_BRD0;
               end
            end
            S_QD: begin
               du_ff <= d_rd;
               state_ff <= S_QDW;
            end
            S_QDW: begin
               // order so that u is the deeper node; depth zero does no lifting
               if (du_ff < d_rd) begin
                  u_ff <= v_ff; v_ff <= u_ff;
                  du_ff <= d_rd; dv_ff <= du_ff;
                  top_ff <= top_of(d_rd);
                  lv_ff <= top_of(d_rd);
                  nolift_ff <= 1'b0;
               end else begin
                  dv_ff <= d_rd;
                  top_ff <= top_of(du_ff);
                  lv_ff <= top_of(du_ff);
                  nolift_ff <= (du_ff == '0);
               end
               state_ff <= S_Q1RD;
            end
            S_Q1RD: begin
               du_ff <= d_rd;
               state_ff <= S_Q1W;
            end
            S_Q1W: begin
               if (q1_lift) begin
                  ans_ff <= mn(ans_ff, t_rd.wt);
                  u_ff <= t_rd.anc[NodeW-1:0];
               end
               if (lv_ff == '0) state_ff <= S_QCHK;
               else begin
                  lv_ff <= lv_ff - 1'b1;
                  state_ff <= S_Q1RD;
               end
            end
            S_QCHK: begin
               lv_ff <= top_ff;
               if (u_ff == v_ff) state_ff <= S_DONE;
               else state_ff <= nolift_ff ? S_QFIN : S_Q2RDU;
            end
            S_Q2RDU: state_ff <= S_Q2RDV;
            S_Q2RDV: begin
               ea_ff <= t_rd;
               state_ff <= S_Q2W;
            end
            S_Q2W: begin
               if (ea_ff.anc < tpmq_pkg::NoNode && t_rd.anc < tpmq_pkg::NoNode
                   && ea_ff.anc != t_rd.anc) begin
                  ans_ff <= mn(ans_ff, mn(ea_ff.wt, t_rd.wt));
                  u_ff <= ea_ff.anc[NodeW-1:0];
                  v_ff <= t_rd.anc[NodeW-1:0];
               end
               if (lv_ff == '0) state_ff <= S_QFIN;
               else begin
                  lv_ff <= lv_ff - 1'b1;
                  state_ff <= S_Q2RDU;
               end
            end
            S_QFIN: state_ff <= S_QFW;
            // u's level-0 weight, then v's
            S_QFW: begin
               ans_ff <= mn(ans_ff, t_rd.wt);
               state_ff <= S_QLAST;
            end
            S_QLAST: begin
               ans_ff <= mn(ans_ff, t_rd.wt);
               state_ff <= S_DONE;
            end
            S_DONE: if (rsp_free) begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && rsp_free) rsp_wt_ff <= ans_ff;
   end

   // Checks
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_min_weight))
      else $error("rsp changed while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && state_ff == S_DONE |=> state_ff == S_DONE)
      else $error("result dropped");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 11'(tpmq_pkg::MaxNodes))
      else $error("node count out of range");
endmodule

FILE: tb/tb_tree_path_min_query.sv
// Testbench for tree_path_min_query: directed table, random trees, scoreboard check.
module tb_tree_path_min_query;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NodeW    = tpmq_pkg::NodeW;
   localparam int AncW     = tpmq_pkg::AncW;
   localparam int WeightW  = tpmq_pkg::WeightW;
   localparam int DepthW   = tpmq_pkg::DepthW;
   localparam int CountW   = tpmq_pkg::CountW;
   localparam int Levels   = tpmq_pkg::Levels;
   localparam int MaxNodes = tpmq_pkg::MaxNodes;

   localparam int CycleLimit = 4000000;
   localparam int HoldCycles = 400;

   // Sender/receiver idle schemes
   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   typedef struct {
      logic [1:0]         kind;
      logic [NodeW-1:0]   node;
      logic [NodeW-1:0]   other;
      logic [NodeW-1:0]   parent;
      logic               has_parent;
      logic [WeightW-1:0] weight;
      logic [DepthW-1:0]  level;
   } req_item_type;

   typedef struct {
      req_item_type       item;
      bit                 typed;
      logic [WeightW-1:0] answer;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic [9:0]         req_node = '0;
   logic [9:0]         req_other_node = '0;
   logic [9:0]         req_parent_node = '0;
   logic               req_has_parent = 1'b0;
   logic [30:0]        req_edge_weight = '0;
   logic [9:0]         req_node_level = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [30:0]        rsp_path_min_weight;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [10:0]        csr_node_count = '0;

   tree_path_min_query dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_node           (req_node),
      .req_other_node     (req_other_node),
      .req_parent_node    (req_parent_node),
      .req_has_parent     (req_has_parent),
      .req_edge_weight    (req_edge_weight),
      .req_node_level     (req_node_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_path_min_weight(rsp_path_min_weight),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_node_count     (csr_node_count)
   );

   always #6 clock = ~clock;

   // Shadow copy of the tree tables
   logic [AncW-1:0]    anc_tab   [Levels][MaxNodes];
   logic [WeightW-1:0] wt_tab    [Levels][MaxNodes];
   logic [DepthW-1:0]  depth_tab [MaxNodes];
   logic [CountW-1:0]  shadow_count = CountW'(1);

   logic [WeightW-1:0] path_min_q [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   idle_mode_type      idle_mode = IdleNone;
   bit                 hold_request = 1'b0;
   int                 hold_left = 0;

   function automatic logic [WeightW-1:0] lesser(input logic [WeightW-1:0] a, b);
      return (a < b) ? a : b;
   endfunction

   function automatic void load_record(input req_item_type it);
      if (it.has_parent) begin
         anc_tab[0][it.node] = {1'b0, it.parent};
         wt_tab[0][it.node]  = it.weight;
      end else begin
         anc_tab[0][it.node] = tpmq_pkg::NoNode;
         wt_tab[0][it.node]  = tpmq_pkg::WeightMax;
      end
      depth_tab[it.node] = it.level;
   endfunction

   // Fill lifting levels 1..Levels-1 for the counted nodes
   function automatic void build_lifting();
      int               cnt;
      logic [AncW-1:0]  a;
      logic [WeightW-1:0] w;
      cnt = (shadow_count > MaxNodes) ? MaxNodes : int'(shadow_count);
      for (int lv = 1; lv < Levels; lv++) begin
         for (int n = 0; n < cnt; n++) begin
            a = anc_tab[lv-1][n];
            w = wt_tab[lv-1][n];
            if (a >= tpmq_pkg::NoNode) begin
               anc_tab[lv][n] = tpmq_pkg::NoNode;
               wt_tab[lv][n]  = w;
            end else begin
               anc_tab[lv][n] = anc_tab[lv-1][a[NodeW-1:0]];
               wt_tab[lv][n]  = lesser(w, wt_tab[lv-1][a[NodeW-1:0]]);
            end
         end
      end
   endfunction

   function automatic logic [WeightW-1:0] path_min(input logic [NodeW-1:0] a_in, b_in);
      logic [NodeW-1:0]   u, v, t;
      logic [WeightW-1:0] best;
      logic [AncW-1:0]    au, av;
      int                 top, d, diff;
      u = a_in;
      v = b_in;
      best = tpmq_pkg::WeightMax;
      if (depth_tab[u] < depth_tab[v]) begin
         t = u; u = v; v = t;
      end
      top = -1;
      d = int'(depth_tab[u]);
      while (d > 1) begin
         d = d >> 1;
         top++;
      end
      if (depth_tab[u] > 0) top++;
      if (top > Levels - 1) top = Levels - 1;
      // lift deeper node to the other's depth
      for (int i = top; i >= 0; i--) begin
         diff = int'(depth_tab[u]) - int'(depth_tab[v]);
         au = anc_tab[i][u];
         if (diff >= (1 << i) && au < tpmq_pkg::NoNode) begin
            best = lesser(best, wt_tab[i][u]);
            u = au[NodeW-1:0];
         end
      end
      if (u == v) return best;
      // lift both to just below the common ancestor
      for (int i = top; i >= 0; i--) begin
         au = anc_tab[i][u];
         av = anc_tab[i][v];
         if (au < tpmq_pkg::NoNode && av < tpmq_pkg::NoNode && au != av) begin
            best = lesser(best, lesser(wt_tab[i][u], wt_tab[i][v]));
            u = au[NodeW-1:0];
            v = av[NodeW-1:0];
         end
      end
      return lesser(best, lesser(wt_tab[0][u], wt_tab[0][v]));
   endfunction

   // Drive one request; typed answer overrides the prediction when given
   task automatic send_req(input req_item_type it, input bit typed = 0,
                           input logic [WeightW-1:0] answer = '0);
      int pct;
      pct = (idle_mode == IdleSender) ? 64 : (idle_mode == IdleBoth) ? 37 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= it.kind;
      req_node        <= it.node;
      req_other_node  <= it.other;
      req_parent_node <= it.parent;
      req_has_parent  <= it.has_parent;
      req_edge_weight <= it.weight;
      req_node_level  <= it.level;
      case (it.kind)
         tpmq_pkg::KindLoad:  load_record(it);
         tpmq_pkg::KindBuild: build_lifting();
         tpmq_pkg::KindQuery:
            path_min_q.push_back(typed ? answer : path_min(it.node, it.other));
         default: ;
      endcase
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_node_count(input logic [CountW-1:0] value);
      req_valid      <= 1'b0;
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      shadow_count = value;
   endtask

   // Wait for every result, then let a build run out
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (path_min_q.size() > 0) @(posedge clock);
      repeat (4 * MaxNodes * Levels / 8 + 4 * int'(shadow_count) * Levels + 200)
         @(posedge clock);
   endtask

   function automatic req_item_type make_item(input logic [1:0] kind, input int n, m, p,
                                              input bit has, input logic [WeightW-1:0] w,
                                              input int lvl);
      req_item_type it;
      it.kind = kind;
      it.node = NodeW'(n);
      it.other = NodeW'(m);
      it.parent = NodeW'(p);
      it.has_parent = has;
      it.weight = w;
      it.level = DepthW'(lvl);
      return it;
   endfunction

   function automatic req_item_type random_query(input int cnt);
      int u, v;
      u = $urandom_range(cnt - 1);
      v = ($urandom_range(9) == 0) ? u : $urandom_range(cnt - 1);
      return make_item(tpmq_pkg::KindQuery, u, v, $urandom_range(1023), $urandom_range(1),
                       WeightW'($urandom), $urandom_range(1023));
   endfunction

   // Load a random tree of cnt nodes, build, then query with some noise mixed in
   task automatic run_tree_phase(input int cfg, input int queries, input bit long_hold);
      int depth_of [MaxNodes];
      int cnt, p, lvl, pick;
      bit has;
      req_item_type it;
      write_node_count(CountW'(cfg));
      cnt = (cfg > MaxNodes) ? MaxNodes : cfg;
      for (int n = 0; n < cnt; n++) begin
         has = (n != 0) && ($urandom_range(19) != 0);
         p = (n == 0) ? $urandom_range(cnt - 1) : $urandom_range(n - 1);
         if ($urandom_range(9) == 0) p = $urandom_range(cnt - 1);
         lvl = has ? depth_of[p] + 1 : 0;
         if ($urandom_range(9) == 0 || lvl > 1023) lvl = $urandom_range(1023);
         depth_of[n] = lvl;
         send_req(make_item(tpmq_pkg::KindLoad, n, $urandom_range(1023), p, has,
                            WeightW'($urandom), lvl));
      end
      send_req(make_item(tpmq_pkg::KindBuild, $urandom_range(1023), $urandom_range(1023),
                         $urandom_range(1023), $urandom_range(1), WeightW'($urandom),
                         $urandom_range(1023)));
      for (int q = 0; q < queries; q++) begin
         if (long_hold && q == queries / 3) hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 5) begin
            it = make_item(tpmq_pkg::KindLoad, $urandom_range(cnt - 1),
                           $urandom_range(1023), $urandom_range(cnt - 1),
                           $urandom_range(1), WeightW'($urandom), $urandom_range(1023));
         end else if (pick < 8) begin
            it = random_query(cnt);
            it.kind = tpmq_pkg::KindBuild;
         end else if (pick < 11) begin
            it = random_query(cnt);
            it.kind = tpmq_pkg::KindUnused;
            it.node = NodeW'($urandom);
         end else begin
            it = random_query(cnt);
         end
         send_req(it);
      end
      drain_and_settle();
   endtask

   // Directed rows: small tree 0-{1,3}, 1-2
   dir_row_type dir_rows [14] = '{
      '{make_item(tpmq_pkg::KindLoad, 0, 1023, 1023, 0, 31'h5555_5555, 0), 0, '0},
      '{make_item(tpmq_pkg::KindLoad, 1, 0, 0, 1, tpmq_pkg::WeightMax, 1), 0, '0},
      '{make_item(tpmq_pkg::KindLoad, 2, 0, 1, 1, 31'd0, 2), 0, '0},
      '{make_item(tpmq_pkg::KindLoad, 3, 0, 0, 1, 31'd5, 1), 0, '0},
      '{make_item(tpmq_pkg::KindUnused, 1023, 1023, 1023, 1, tpmq_pkg::WeightMax, 1023),
        0, '0},
      '{make_item(tpmq_pkg::KindBuild, 0, 0, 0, 0, 31'd0, 0), 0, '0},
      '{make_item(tpmq_pkg::KindQuery, 2, 2, 0, 0, 31'd0, 0), 1, tpmq_pkg::WeightMax},
      '{make_item(tpmq_pkg::KindQuery, 1, 0, 0, 0, 31'd0, 0), 1, tpmq_pkg::WeightMax},
      '{make_item(tpmq_pkg::KindQuery, 2, 0, 0, 0, 31'd0, 0), 1, 31'd0},
      '{make_item(tpmq_pkg::KindQuery, 3, 0, 0, 0, 31'd0, 0), 1, 31'd5},
      '{make_item(tpmq_pkg::KindQuery, 0, 3, 0, 0, 31'd0, 0), 1, 31'd5},
      '{make_item(tpmq_pkg::KindQuery, 2, 3, 1023, 1, tpmq_pkg::WeightMax, 1023), 1, 31'd0},
      '{make_item(tpmq_pkg::KindUnused, 0, 0, 0, 0, 31'd0, 0), 0, '0},
      '{make_item(tpmq_pkg::KindQuery, 3, 1, 0, 0, 31'd0, 0), 0, '0}
   };

   // Receiver ready, with random stalls and one long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HoldCycles;
         rsp_ready <= 1'b0;
      end else if (idle_mode == IdleReceiver) begin
         rsp_ready <= ($urandom_range(99) >= 64);
      end else if (idle_mode == IdleBoth) begin
         rsp_ready <= ($urandom_range(99) >= 37);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (path_min_q.size() == 0) begin
            $display("%0t: unexpected result path_min_weight=%0d", $realtime,
                     rsp_path_min_weight);
            error_count++;
         end else begin
            if (rsp_path_min_weight !== path_min_q[0]) begin
               $display("%0t: path_min_weight mismatch expected=%0d actual=%0d",
                        $realtime, path_min_q[0], rsp_path_min_weight);
               error_count++;
            end
            void'(path_min_q.pop_front());
         end
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tree_path_min_query regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      write_node_count(CountW'(4));
      foreach (dir_rows[r]) send_req(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].answer);
      drain_and_settle();

      // random trees over several sizes and idle schemes
      idle_mode = IdleSender;
      run_tree_phase(1, 20, 0);
      idle_mode = IdleReceiver;
      run_tree_phase(2, 30, 0);

      // zero count builds nothing; nodes 0..3 are all loaded and built
      idle_mode = IdleNone;
      write_node_count(CountW'(0));
      send_req(make_item(tpmq_pkg::KindBuild, 0, 0, 0, 0, 31'd0, 0));
      repeat (30) send_req(random_query(4));
      drain_and_settle();

      idle_mode = IdleNone;
      run_tree_phase(37, 120, 1);
      idle_mode = IdleSender;
      run_tree_phase(150, 80, 0);
      idle_mode = IdleReceiver;
      run_tree_phase(13, 80, 0);
      idle_mode = IdleBoth;
      run_tree_phase(64, 60, 0);

      if (error_count == 0 && path_min_q.size() == 0) begin
         $display("tree_path_min_query regression: pass");
      end else begin
         $display("tree_path_min_query regression: fail");
      end
      $finish;
   end

endmodule
